>>> sv/dbt_pkg.sv
// Package: shared types, constants and cell-index helpers for the board transform store.
`timescale 1ns / 1ps
package dbt_pkg;

  // Geometry and storage
  localparam int SIDE       = 9;
  localparam int PLANES     = 16;
  localparam int VALUE_BITS = 32;

  localparam int CELLS   = SIDE * SIDE;
  localparam int STRIDE  = CELLS + 1;
  localparam int DEPTH   = PLANES * STRIDE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COORD_W = $clog2(SIDE);
  localparam int CELL_W  = $clog2(CELLS + 1);

  // Fixed port widths
  localparam int PLANE_W = 4;
  localparam int REQ_W   = 7;
  localparam int VIEW_W  = 3;
  localparam int DATA_W  = 32;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  // Codes
  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_READ      = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Classified command handed from front to back
  typedef struct packed {
    logic                  is_read;
    logic                  bad;
    logic [ADDR_W-1:0]     addr;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

  // Row of a row-major cell index (cell below CELLS)
  function automatic logic [COORD_W-1:0] row_of(input logic [CELL_W-1:0] c);
    logic [COORD_W-1:0] r;
    r = '0;
    for (int k = 1; k < SIDE; k++) begin
      if (int'(c) >= k * SIDE) r = COORD_W'(k);
    end
    return r;
  endfunction

endpackage

>>> sv/dbt_front.sv
// Front end: holds the pass flag, range-checks requests and maps view targets to store addresses.
`timescale 1ns / 1ps
module dbt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_op,
  input  logic [dbt_pkg::PLANE_W-1:0]   in_plane,
  input  logic [dbt_pkg::REQ_W-1:0]     in_cell_req,
  input  logic [dbt_pkg::VIEW_W-1:0]    in_view,
  input  logic [dbt_pkg::DATA_W-1:0]    in_cell_value,
  output dbt_pkg::cmd_t                 cmd
);
  import dbt_pkg::*;

  logic               pass_included_r;
  logic [CELL_W-1:0]  cell_idx;
  logic [COORD_W-1:0] ti, tj, ri, rj, si;
  logic [CELL_W-1:0]  src;
  logic               bad;
  logic               is_pass;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_included_r <= 1'b0;
    end else if (cfg_we) begin
      pass_included_r <= cfg_wdata;
    end
  end

  // Range check
  always_comb begin
    cell_idx = CELL_W'(in_cell_req);
    is_pass  = (int'(in_cell_req) == CELLS);
    bad      = (int'(in_plane) >= PLANES) || (int'(in_cell_req) > CELLS) ||
               (is_pass && !pass_included_r);
  end

  // Target coordinates, quarter turns, then optional row flip
  always_comb begin
    ti = row_of(cell_idx);
    tj = COORD_W'(cell_idx - CELL_W'(ti) * CELL_W'(SIDE));
    case (in_view[1:0])
      2'd0: begin
        ri = ti;
        rj = tj;
      end
      2'd1: begin
        ri = COORD_W'(SIDE - 1) - tj;
        rj = ti;
      end
      2'd2: begin
        ri = COORD_W'(SIDE - 1) - ti;
        rj = COORD_W'(SIDE - 1) - tj;
      end
      2'd3: begin
        ri = tj;
        rj = COORD_W'(SIDE - 1) - ti;
      end
      default: begin
        ri = ti;
        rj = tj;
      end
    endcase
    si = in_view[2] ? COORD_W'(SIDE - 1) - ri : ri;
    // pass slot reads through in every view; writes go straight to the target
    if (is_pass || in_op == OP_WRITE) begin
      src = cell_idx;
    end else begin
      src = CELL_W'(si) * CELL_W'(SIDE) + CELL_W'(rj);
    end
  end

  // Command out to the queue
  always_comb begin
    cmd.is_read = (in_op == OP_READ);
    cmd.bad     = bad;
    cmd.addr    = ADDR_W'(in_plane) * ADDR_W'(STRIDE) + ADDR_W'(src);
    cmd.value   = VALUE_BITS'(in_cell_value);
  end

endmodule

>>> sv/dbt_queue.sv
// Short command queue decoupling the front end from the store back end.
`timescale 1ns / 1ps
module dbt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dbt_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output dbt_pkg::cmd_t pop_data
);
  import dbt_pkg::*;

  cmd_t             entry_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (int'(count_r) == QDEPTH);
  assign not_empty = (count_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (int'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop)  rd_ptr_nxt = (int'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= QDEPTH) else $error("queue count over depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("pointers apart while empty");

endmodule

>>> sv/dbt_back.sv
// Back end: plane store memory, registered read and the output register.
`timescale 1ns / 1ps
module dbt_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_not_empty,
  input  dbt_pkg::cmd_t                q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dbt_pkg::DATA_W-1:0]   out_read_value,
  output logic                         out_status
);
  import dbt_pkg::*;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_read_r, s1_bad_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]     out_value_r;
  logic                  out_status_r;
  logic                  s1_adv;

  // Stage advance: output register drains, read stage moves up, queue pops
  assign s1_adv = s1_valid_r && (!out_valid_r || out_ready);
  assign q_pop  = q_not_empty && (!s1_valid_r || s1_adv);

  always_comb begin
    s1_valid_nxt  = q_pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Plane store: one access per popped in-range command
  always_ff @(posedge clk) begin
    if (q_pop && !q_data.bad) begin
      if (q_data.is_read) rdata_r <= mem[q_data.addr];
      else                mem[q_data.addr] <= q_data.value;
    end
  end

  // Read stage flags
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_read_r <= q_data.is_read;
      s1_bad_r  <= q_data.bad;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value_r  <= (s1_read_r && !s1_bad_r) ? DATA_W'(rdata_r) : '0;
      out_status_r <= s1_bad_r ? STATUS_RANGE : STATUS_OK;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

  // Checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_RANGE) |-> (out_value_r == '0))
    else $error("error result carries data");
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r) else $error("advanced item lost");
  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && s1_valid_r) |-> s1_adv) else $error("pop over a stalled read stage");

endmodule

>>> sv/dihedral_board_transform_store.sv
// Top level: dihedral board transform store, front end, queue and store back end.
//
//  channel | signals                                             | dir
//  in      | in_valid in_ready in_op in_plane in_cell_req        | in
//          | in_view in_cell_value                               |
//  out     | out_valid out_ready out_read_value out_status       | out
//  cfg     | cfg_we cfg_wdata (pass_included)                    | in
//
// Sustained rate: one transfer per cycle on each side while out_ready stays high; the single plane store port
// takes one access per cycle.
// Path: the input transfer is written into the queue, popped into the memory read stage, then
// moved into the output register, which raises out_valid.
// Reset: synchronous active-low rst_n clears control only; store contents are
// undefined until written and need no clearing.
// Stalls: the two-entry queue and the output register let either side stall on its own.
`timescale 1ns / 1ps
module dihedral_board_transform_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [dbt_pkg::PLANE_W-1:0]   in_plane,
  input  logic [dbt_pkg::REQ_W-1:0]     in_cell_req,
  input  logic [dbt_pkg::VIEW_W-1:0]    in_view,
  input  logic [dbt_pkg::DATA_W-1:0]    in_cell_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dbt_pkg::DATA_W-1:0]    out_read_value,
  output logic                          out_status
);
  import dbt_pkg::*;

  cmd_t front_cmd, q_data;
  logic q_full, q_not_empty, q_pop, push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  dbt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_op         (in_op),
    .in_plane      (in_plane),
    .in_cell_req   (in_cell_req),
    .in_view       (in_view),
    .in_cell_value (in_cell_value),
    .cmd           (front_cmd)
  );

  dbt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  dbt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

endmodule

>>> test/dihedral_board_transform_store_tb.sv
// Testbench for the dihedral board transform store: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps
module dihedral_board_transform_store_tb;
  import dbt_pkg::*;

  // Directed table controls
  localparam logic [1:0] CFG_KEEP     = 2'd0;
  localparam logic [1:0] CFG_PASS_OFF = 2'd1;
  localparam logic [1:0] CFG_PASS_ON  = 2'd2;
  localparam logic       CHK_PRED     = 1'b0;
  localparam logic       CHK_TYPED    = 1'b1;

  localparam int RANDOM_PER_PHASE = 275;
  localparam int PRINT_CAP        = 40;

  typedef struct packed {
    logic               op;
    logic [PLANE_W-1:0] plane;
    logic [REQ_W-1:0]   cell_idx;
    logic [VIEW_W-1:0]  view;
    logic [DATA_W-1:0]  value;
  } board_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              status;
  } board_answer_t;

  typedef struct packed {
    logic          typed;
    board_answer_t ans;
  } row_check_t;

  typedef struct packed {
    logic [1:0]         cfg;
    logic               op;
    logic [PLANE_W-1:0] plane;
    logic [REQ_W-1:0]   cell_idx;
    logic [VIEW_W-1:0]  view;
    logic [DATA_W-1:0]  value;
    logic               typed;
    logic [DATA_W-1:0]  exp_value;
    logic               exp_status;
  } dir_row_t;

  // Directed rows: range errors, corner writes, every view, pass slot and register toggles
  dir_row_t dir_rows [0:22] = '{
    // pass slot while the register is still at its reset value
    '{CFG_KEEP, OP_WRITE, 4'd0, 7'(CELLS), 3'd0, 32'h1234_5678, CHK_TYPED, 32'h0, STATUS_RANGE},
    // cell index far past the board
    '{CFG_KEEP, OP_WRITE, 4'd0, 7'd127, 3'd7, 32'hFFFF_FFFF, CHK_TYPED, 32'h0, STATUS_RANGE},
    '{CFG_KEEP, OP_READ, 4'd0, 7'(CELLS), 3'd0, 32'h0, CHK_TYPED, 32'h0, STATUS_RANGE},
    '{CFG_KEEP, OP_READ, 4'd15, 7'(CELLS + 1), 3'd7, 32'h0, CHK_TYPED, 32'h0, STATUS_RANGE},
    // four corners of plane 0
    '{CFG_KEEP, OP_WRITE, 4'd0, 7'd0, 3'd7, 32'hFFFF_FFFF, CHK_TYPED, 32'h0, STATUS_OK},
    '{CFG_KEEP, OP_WRITE, 4'd0, 7'(SIDE - 1), 3'd0, 32'h0, CHK_TYPED, 32'h0, STATUS_OK},
    '{CFG_KEEP, OP_WRITE, 4'd0, 7'(CELLS - SIDE), 3'd3, 32'hA5A5_A5A5, CHK_TYPED, 32'h0,
      STATUS_OK},
    '{CFG_KEEP, OP_WRITE, 4'd0, 7'(CELLS - 1), 3'd4, 32'h5A5A_5A5A, CHK_TYPED, 32'h0,
      STATUS_OK},
    // cell 0 under all eight views lands on the corners
    '{CFG_KEEP, OP_READ, 4'd0, 7'd0, 3'd0, 32'hFFFF_FFFF, CHK_PRED, 32'h0, STATUS_OK},
    '{CFG_KEEP, OP_READ, 4'd0, 7'd0, 3'd1, 32'hFFFF_FFFF, CHK_PRED, 32'h0, STATUS_OK},
    '{CFG_KEEP, OP_READ, 4'd0, 7'd0, 3'd2, 32'hFFFF_FFFF, CHK_PRED, 32'h0, STATUS_OK},
    '{CFG_KEEP, OP_READ, 4'd0, 7'd0, 3'd3, 32'hFFFF_FFFF, CHK_PRED, 32'h0, STATUS_OK},
    '{CFG_KEEP, OP_READ, 4'd0, 7'd0, 3'd4, 32'hFFFF_FFFF, CHK_PRED, 32'h0, STATUS_OK},
    '{CFG_KEEP, OP_READ, 4'd0, 7'd0, 3'd5, 32'hFFFF_FFFF, CHK_PRED, 32'h0, STATUS_OK},
    '{CFG_KEEP, OP_READ, 4'd0, 7'd0, 3'd6, 32'hFFFF_FFFF, CHK_PRED, 32'h0, STATUS_OK},
    '{CFG_KEEP, OP_READ, 4'd0, 7'd0, 3'd7, 32'hFFFF_FFFF, CHK_PRED, 32'h0, STATUS_OK},
    // pass slot enabled: write, then read through a flipped view
    '{CFG_PASS_ON, OP_WRITE, 4'd15, 7'(CELLS), 3'd0, 32'hDEAD_BEEF, CHK_TYPED, 32'h0,
      STATUS_OK},
    '{CFG_KEEP, OP_READ, 4'd15, 7'(CELLS), 3'd5, 32'h0, CHK_TYPED, 32'hDEAD_BEEF, STATUS_OK},
    '{CFG_KEEP, OP_WRITE, 4'd15, 7'd0, 3'd2, 32'h0000_0001, CHK_TYPED, 32'h0, STATUS_OK},
    '{CFG_KEEP, OP_READ, 4'd15, 7'(CELLS - 1), 3'd2, 32'h0, CHK_PRED, 32'h0, STATUS_OK},
    // toggling the register keeps the pass entry intact
    '{CFG_PASS_OFF, OP_READ, 4'd15, 7'(CELLS), 3'd0, 32'h0, CHK_TYPED, 32'h0, STATUS_RANGE},
    '{CFG_PASS_ON, OP_READ, 4'd15, 7'(CELLS), 3'd3, 32'h0, CHK_TYPED, 32'hDEAD_BEEF,
      STATUS_OK},
    // one past the pass slot is still out of range
    '{CFG_KEEP, OP_WRITE, 4'd0, 7'(CELLS + 1), 3'd1, 32'h0, CHK_TYPED, 32'h0, STATUS_RANGE}
  };

  // DUT signals
  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cfg_we        = 1'b0;
  logic               cfg_wdata     = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic               in_op         = OP_WRITE;
  logic [PLANE_W-1:0] in_plane      = '0;
  logic [REQ_W-1:0]   in_cell_req   = '0;
  logic [VIEW_W-1:0]  in_view       = '0;
  logic [DATA_W-1:0]  in_cell_value = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [DATA_W-1:0]  out_read_value;
  logic               out_status;

  // Scoreboard state
  logic [VALUE_BITS-1:0] plane_mem [PLANES*STRIDE];
  bit                    cell_filled [PLANES*STRIDE];
  board_answer_t         board_answers [$];
  row_check_t            row_checks [$];
  logic                  pass_on   = 1'b0;
  logic                  gen_pass  = 1'b0;
  int                    in_gap_pct    = 0;
  int                    out_stall_pct = 0;
  int                    mismatch_count = 0;

  dihedral_board_transform_store u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_plane      (in_plane),
    .in_cell_req   (in_cell_req),
    .in_view       (in_view),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_value(out_read_value),
    .out_status    (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic bit out_of_range(input logic [PLANE_W-1:0] plane,
                                      input logic [REQ_W-1:0] cell_idx, input logic pass);
    return int'(plane) >= PLANES || int'(cell_idx) > CELLS ||
           (int'(cell_idx) == CELLS && !pass);
  endfunction

  // Source cell of a target cell: quarter turns, then the optional row flip
  function automatic int view_source(input int cell_idx, input int view);
    int row;
    int col;
    int tmp;
    row = cell_idx / SIDE;
    col = cell_idx % SIDE;
    for (int k = 0; k < (view & 3); k++) begin
      tmp = row;
      row = SIDE - 1 - col;
      col = tmp;
    end
    if (view & 4) row = SIDE - 1 - row;
    return row * SIDE + col;
  endfunction

  // Applies one transfer to the board model and returns its answer
  function automatic board_answer_t predict_access(input board_req_t r);
    board_answer_t a;
    int base;
    int src;
    a.value  = '0;
    a.status = STATUS_OK;
    if (out_of_range(r.plane, r.cell_idx, pass_on)) begin
      a.status = STATUS_RANGE;
      return a;
    end
    base = int'(r.plane) * STRIDE;
    if (r.op == OP_WRITE) begin
      plane_mem[base + int'(r.cell_idx)] = r.value[VALUE_BITS-1:0];
    end else begin
      src = (int'(r.cell_idx) == CELLS) ? CELLS
                                        : view_source(int'(r.cell_idx), int'(r.view));
      a.value = DATA_W'(plane_mem[base + src]);
    end
    return a;
  endfunction

  // Mostly legal traffic on a few hot planes; reads of unwritten cells become fills
  function automatic board_req_t random_item();
    board_req_t r;
    int src;
    r.op    = ($urandom_range(1) == 0) ? OP_WRITE : OP_READ;
    r.view  = VIEW_W'($urandom);
    r.value = $urandom;
    if ($urandom_range(99) < 8) begin
      r.plane    = PLANE_W'($urandom);
      r.cell_idx = REQ_W'($urandom);
    end else begin
      r.plane    = ($urandom_range(99) < 70) ? PLANE_W'($urandom_range(3))
                                             : PLANE_W'($urandom_range(PLANES - 1));
      r.cell_idx = ($urandom_range(99) < 10) ? REQ_W'(CELLS)
                                             : REQ_W'($urandom_range(CELLS - 1));
    end
    if (r.op == OP_READ && !out_of_range(r.plane, r.cell_idx, gen_pass)) begin
      src = (int'(r.cell_idx) == CELLS) ? CELLS
                                        : view_source(int'(r.cell_idx), int'(r.view));
      if (!cell_filled[int'(r.plane) * STRIDE + src]) begin
        r.op       = OP_WRITE;
        r.cell_idx = REQ_W'(src);
      end
    end
    return r;
  endfunction

  // Drives one item and returns at the edge where it transfers
  task automatic send_item(input board_req_t r, input row_check_t chk);
    if (r.op == OP_WRITE && !out_of_range(r.plane, r.cell_idx, gen_pass))
      cell_filled[int'(r.plane) * STRIDE + int'(r.cell_idx)] = 1'b1;
    row_checks.insert(row_checks.size(), chk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= r.op;
    in_plane      <= r.plane;
    in_cell_req   <= r.cell_idx;
    in_view       <= r.view;
    in_cell_value <= r.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Register write once every pending answer is back and the pipeline has settled
  task automatic set_pass_slot(input logic v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (board_answers.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    gen_pass  = v;
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Track register writes, predict on input transfers, check output transfers
  always @(posedge clk) begin : watch
    board_req_t    r;
    board_answer_t pred;
    board_answer_t want;
    row_check_t    chk;
    if (rst_n) begin
      if (cfg_we) pass_on = cfg_wdata;
      if (in_valid && in_ready) begin
        r    = '{in_op, in_plane, in_cell_req, in_view, in_cell_value};
        pred = predict_access(r);
        chk  = row_checks.pop_front();
        board_answers.insert(board_answers.size(), (chk.typed == CHK_TYPED) ? chk.ans : pred);
      end
      if (out_valid && out_ready) begin
        if (board_answers.size() == 0) begin
          report_mismatch("result transfer with nothing pending");
        end else begin
          want = board_answers.pop_front();
          if (out_read_value !== want.value)
            report_mismatch($sformatf("read_value got %h want %h", out_read_value, want.value));
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %b want %b", out_status, want.status));
        end
      end
    end
  end

  initial begin : stimulus
    board_req_t r;
    row_check_t chk;
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    in_gap_pct    = 30;
    out_stall_pct = 51;
    foreach (dir_rows[n]) begin
      if (dir_rows[n].cfg == CFG_PASS_ON) set_pass_slot(1'b1);
      else if (dir_rows[n].cfg == CFG_PASS_OFF) set_pass_slot(1'b0);
      r = '{dir_rows[n].op, dir_rows[n].plane, dir_rows[n].cell_idx, dir_rows[n].view,
            dir_rows[n].value};
      chk.typed      = dir_rows[n].typed;
      chk.ans.value  = dir_rows[n].exp_value;
      chk.ans.status = dir_rows[n].exp_status;
      send_item(r, chk);
    end

    // Random phases: idle mix changes every two phases, register flips every phase
    chk = '0;
    chk.typed = CHK_PRED;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          in_gap_pct    = 30;
          out_stall_pct = 51;
        end
        1: begin
          in_gap_pct    = 51;
          out_stall_pct = 30;
        end
        default: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
      endcase
      set_pass_slot((phase % 2) == 0);
      repeat (RANDOM_PER_PHASE) send_item(random_item(), chk);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain
    waited = 0;
    while (board_answers.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (board_answers.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", board_answers.size()));
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/dbt_pkg.sv
sv/dbt_front.sv
sv/dbt_queue.sv
sv/dbt_back.sv
sv/dihedral_board_transform_store.sv
test/dihedral_board_transform_store_tb.sv
